// ===== rtl/oaht_pkg.sv =====
package oaht_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 64;

    localparam int S_TDATA_W = KEY_W + HASH_W + LEN_W + VAL_W;
    localparam int M_BITS_W  = 1 + VAL_W + KEY_W + 1;
    localparam int M_TDATA_W = ((M_BITS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_BITS_W;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_USED  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [VAL_W-1:0]  value_in;
        logic [LEN_W-1:0]  key_length;
        logic [HASH_W-1:0] key_hash;
        logic [KEY_W-1:0]  key_id;
    } in_beat_t;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic               full_res;
        logic [KEY_W-1:0]   key_out;
        logic [VAL_W-1:0]   value_out;
        logic               hit;
    } out_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic clear_step;
        logic start;
        logic check;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic skip;
        logic done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/open_addressing_hash_table_core.sv =====
// Open-addressing hash table with linear probing and tombstones.
// Input channel (s_): one request per beat; tuser carries the operation (get, set,
// remove, find by hash and length), tdata the key identity, hash, length and value.
// Result channel (m_): exactly one beat per request, with hit, value, key and the
// full flag that marks a set refused at three-quarter load.
// Each probed slot takes a registered read of the slot memories and a compare
// step. A request is answered once probing ends, and the next beat is taken only
// after the result has been loaded into the output register. Get, remove and find
// on an empty table skip probing.
// After reset the tag memory is swept to empty, one slot per cycle, and s_tready
// stays low until the sweep has reached the last slot.
// The result sits in an output register. While the receiver stalls the block still
// accepts and works on one further request, and then waits with s_tready low until
// the held beat has been taken.
module open_addressing_hash_table_core #(
    parameter int SLOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_id[31:0], key_hash[63:32], key_length[79:64], value_in[143:80]
    input  logic [oaht_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [oaht_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit[0], value_out[64:1], key_out[96:65], full_res[97], zeros[103:98]
    output logic [oaht_pkg::M_TDATA_W-1:0] m_tdata
);

    oaht_pkg::cmd_t    cmd;
    oaht_pkg::status_t st;

    oaht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    oaht_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/oaht_ctrl.sv =====
module oaht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  oaht_pkg::status_t st,
    output oaht_pkg::cmd_t    cmd
);

    oaht_pkg::state_t state_reg;
    oaht_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oaht_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            oaht_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_last) begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = oaht_pkg::ST_READ;
                end
            end
            oaht_pkg::ST_READ: begin
                // An empty table answers lookups without probing.
                if (st.skip) begin
                    state_next = oaht_pkg::ST_DONE;
                end else begin
                    state_next = oaht_pkg::ST_CHECK;
                end
            end
            oaht_pkg::ST_CHECK: begin
                cmd.check = 1'b1;
                if (st.done) begin
                    state_next = oaht_pkg::ST_DONE;
                end else begin
                    state_next = oaht_pkg::ST_READ;
                end
            end
            oaht_pkg::ST_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = oaht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = oaht_pkg::ST_CLEAR;
            end
        endcase
    end

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == oaht_pkg::ST_CHECK |-> $past(state_reg) == oaht_pkg::ST_READ)
        else $error("slot checked without a preceding read");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == oaht_pkg::ST_DONE && !st.out_free) |=> state_reg == oaht_pkg::ST_DONE)
        else $error("result left before the output register was free");

endmodule

// ===== rtl/oaht_datapath.sv =====
module oaht_datapath #(
    parameter int SLOTS = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  oaht_pkg::cmd_t                   cmd,
    output oaht_pkg::status_t                st,
    input  logic [oaht_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [oaht_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [oaht_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LOAD_W = IDX_W + 3;
    localparam logic [LOAD_W-1:0] LOAD_LIMIT = LOAD_W'(3 * SLOTS);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(SLOTS - 1);

    oaht_pkg::tag_t   tag_mem [SLOTS];
    oaht_pkg::entry_t entry_mem [SLOTS];

    oaht_pkg::in_beat_t  in_beat;
    oaht_pkg::out_beat_t out_beat;

    oaht_pkg::op_t               op_reg;
    oaht_pkg::entry_t            req_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            n_reg;
    logic [IDX_W-1:0]            tomb_reg;
    logic                        tomb_valid_reg;
    logic [CNT_W-1:0]            used_count_reg;
    oaht_pkg::tag_t              tag_rd_reg;
    oaht_pkg::entry_t            entry_rd_reg;
    logic                        res_hit_reg;
    logic                        res_full_reg;
    logic [oaht_pkg::VAL_W-1:0]  res_value_reg;
    logic [oaht_pkg::KEY_W-1:0]  res_key_reg;
    logic                        m_tvalid_reg;
    logic [oaht_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                        is_empty;
    logic                        is_used;
    logic                        is_tomb;
    logic                        key_hit;
    logic                        find_hit;
    logic                        last_probe;
    logic                        done;
    logic                        finish;
    logic                        cand_tomb_valid;
    logic [IDX_W-1:0]            cand_tomb;
    logic                        load_full;
    logic                        set_ok;
    logic                        set_new_empty;
    logic [IDX_W-1:0]            set_target;
    logic                        tag_we;
    logic [IDX_W-1:0]            tag_waddr;
    oaht_pkg::tag_t              tag_wdata;
    logic                        entry_we;
    logic                        res_hit_next;
    logic                        res_full_next;
    logic [oaht_pkg::VAL_W-1:0]  res_value_next;
    logic [oaht_pkg::KEY_W-1:0]  res_key_next;

    assign in_beat = oaht_pkg::in_beat_t'(s_tdata);

    assign is_empty   = tag_rd_reg == oaht_pkg::TAG_EMPTY;
    assign is_used    = tag_rd_reg == oaht_pkg::TAG_USED;
    assign is_tomb    = !is_empty && !is_used;
    assign key_hit    = is_used && entry_rd_reg.key == req_reg.key;
    assign find_hit   = is_used && entry_rd_reg.hash == req_reg.hash
                      && entry_rd_reg.len == req_reg.len;
    assign last_probe = n_reg == IDX_LAST;
    assign done       = (op_reg == oaht_pkg::OP_FIND)
                      ? (is_empty || find_hit || last_probe)
                      : (is_empty || key_hit || last_probe);
    assign finish     = cmd.check && done;

    // The tombstone seen in this very cycle counts, so the last probe can still use it.
    assign cand_tomb_valid = tomb_valid_reg || is_tomb;
    assign cand_tomb       = tomb_valid_reg ? tomb_reg : idx_reg;

    assign load_full     = ((LOAD_W'(used_count_reg) + LOAD_W'(1)) << 2) > LOAD_LIMIT;
    assign set_new_empty = !key_hit && !cand_tomb_valid && is_empty;
    assign set_ok        = key_hit || cand_tomb_valid || (is_empty && !load_full);
    assign set_target    = (!key_hit && cand_tomb_valid) ? cand_tomb : idx_reg;

    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = idx_reg;
        tag_wdata = oaht_pkg::TAG_EMPTY;
        entry_we  = 1'b0;
        if (cmd.clear_step) begin
            tag_we = 1'b1;
        end else if (finish && op_reg == oaht_pkg::OP_REMOVE && key_hit) begin
            tag_we    = 1'b1;
            tag_wdata = oaht_pkg::TAG_TOMB;
        end else if (finish && op_reg == oaht_pkg::OP_SET && set_ok) begin
            entry_we  = 1'b1;
            tag_we    = !key_hit;
            tag_waddr = set_target;
            tag_wdata = oaht_pkg::TAG_USED;
        end
    end

    always_comb begin
        res_hit_next   = 1'b0;
        res_full_next  = 1'b0;
        res_value_next = '0;
        res_key_next   = '0;
        case (op_reg)
            oaht_pkg::OP_GET: begin
                res_hit_next   = key_hit;
                res_value_next = key_hit ? entry_rd_reg.value : '0;
            end
            oaht_pkg::OP_SET: begin
                res_hit_next  = set_ok && !key_hit;
                res_full_next = !set_ok;
            end
            oaht_pkg::OP_REMOVE: begin
                res_hit_next = key_hit;
            end
            oaht_pkg::OP_FIND: begin
                res_hit_next = find_hit;
                res_key_next = find_hit ? entry_rd_reg.key : '0;
            end
            default: begin
                res_hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (entry_we) begin
            entry_mem[set_target] <= req_reg;
        end
        tag_rd_reg   <= tag_mem[idx_reg];
        entry_rd_reg <= entry_mem[idx_reg];
    end

    // The slot index doubles as the address counter of the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            n_reg          <= '0;
            tomb_valid_reg <= 1'b0;
        end else if (cmd.clear_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end else if (cmd.start) begin
            idx_reg        <= in_beat.key_hash[IDX_W-1:0];
            n_reg          <= '0;
            tomb_valid_reg <= 1'b0;
        end else if (cmd.check && !done) begin
            idx_reg <= idx_reg + IDX_W'(1);
            n_reg   <= n_reg + IDX_W'(1);
            if (is_tomb) begin
                tomb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check && !done && is_tomb && !tomb_valid_reg) begin
            tomb_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
        end else if (finish && op_reg == oaht_pkg::OP_SET && set_new_empty && !load_full) begin
            used_count_reg <= used_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg         <= oaht_pkg::op_t'(s_tuser);
            req_reg.key    <= in_beat.key_id;
            req_reg.hash   <= in_beat.key_hash;
            req_reg.len    <= in_beat.key_length;
            req_reg.value  <= in_beat.value_in;
            res_hit_reg    <= 1'b0;
            res_full_reg   <= 1'b0;
            res_value_reg  <= '0;
            res_key_reg    <= '0;
        end else if (finish) begin
            res_hit_reg    <= res_hit_next;
            res_full_reg   <= res_full_next;
            res_value_reg  <= res_value_next;
            res_key_reg    <= res_key_next;
        end
    end

    always_comb begin
        out_beat           = '0;
        out_beat.hit       = res_hit_reg;
        out_beat.value_out = res_value_reg;
        out_beat.key_out   = res_key_reg;
        out_beat.full_res  = res_full_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_beat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign st.clear_last = idx_reg == IDX_LAST;
    assign st.skip       = used_count_reg == '0 && op_reg != oaht_pkg::OP_SET;
    assign st.done       = done;
    assign st.out_free   = !m_tvalid_reg || m_tready;

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (LOAD_W'(used_count_reg) << 2) <= LOAD_LIMIT)
        else $error("occupied slot count passed three quarters of capacity");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && used_count_reg != $past(used_count_reg))
        |-> used_count_reg == $past(used_count_reg) + CNT_W'(1))
        else $error("occupied slot count moved by other than one");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded over an unread beat");

endmodule
